// ===== hdl/rbs_pkg.sv =====
// Shared constants and types for the ray/box slab intersection unit.
package rbs_pkg;

    // Default coordinate width (signed Q16.16)
    localparam int COORD_WIDTH_DEF = 32;

    // Number of configuration registers
    localparam int NUM_REGS = 6;

    // Normalized sum-of-squares field and its integer square root
    localparam int SQ_WIDTH    = 126;
    localparam int ROOT_WIDTH  = 63;
    localparam int SHIFT_WIDTH = 6;

    // Split of the root for the distance partial products
    localparam int LO_W = 32;
    localparam int HI_W = ROOT_WIDTH - LO_W;

    // Control bits that travel with each beat down the pipeline
    typedef struct packed {
        logic valid;
        logic hit;
        logic neg;
    } t_ctl;

endpackage

// ===== hdl/rbs_slab_front.sv =====
// Slab setup, entry/exit merge, hit decision and root-operand normalization.
module rbs_slab_front #(
    parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic                                  i_action,
    input  logic signed [COORD_WIDTH-1:0]         i_origin [3],
    input  logic signed [COORD_WIDTH-1:0]         i_vector [3],
    input  logic signed [COORD_WIDTH-1:0]         i_center [3],
    input  logic        [COORD_WIDTH-2:0]         i_half [3],
    output rbs_pkg::t_ctl                         o_ctl,
    output logic        [rbs_pkg::SQ_WIDTH-1:0]   o_x,
    output logic        [rbs_pkg::SHIFT_WIDTH-1:0] o_k,
    output logic        [COORD_WIDTH:0]           o_men,
    output logic        [COORD_WIDTH-1:0]         o_ed
);
    import rbs_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int NW = CW + 2;      // signed crossing numerator
    localparam int MW = CW + 1;      // numerator magnitude
    localparam int QW = 2 * CW;      // squared direction component
    localparam int SW = 2 * CW + 2;  // sum of three squares

    localparam logic [1:0] SG_NEG  = 2'd0;
    localparam logic [1:0] SG_ZERO = 2'd1;
    localparam logic [1:0] SG_POS  = 2'd2;

    typedef struct packed {
        logic                 have;
        logic signed [NW-1:0] en;
        logic        [CW-1:0] ed;
        logic signed [NW-1:0] xn;
        logic        [CW-1:0] xd;
    } t_span;

    function automatic logic [MW-1:0] mag_of(input logic signed [NW-1:0] n);
        return n[NW-1] ? MW'(-n) : MW'(n);
    endfunction

    function automatic logic [1:0] sign_of(input logic signed [NW-1:0] n);
        logic [1:0] g;
        if (n[NW-1]) g = SG_NEG;
        else if (n == '0) g = SG_ZERO;
        else g = SG_POS;
        return g;
    endfunction

    // True when n1/d1 > n2/d2 (denominators positive), by cross products
    function automatic logic frac_gt(input logic signed [NW-1:0] n1,
                                     input logic        [CW-1:0] d1,
                                     input logic signed [NW-1:0] n2,
                                     input logic        [CW-1:0] d2);
        logic [MW+CW-1:0] p1;
        logic [MW+CW-1:0] p2;
        logic [1:0]       g1;
        logic [1:0]       g2;
        logic             res;
        p1 = (MW+CW)'(mag_of(n1)) * (MW+CW)'(d2);
        p2 = (MW+CW)'(mag_of(n2)) * (MW+CW)'(d1);
        g1 = sign_of(n1);
        g2 = sign_of(n2);
        priority if (g1 != g2) res = (g1 > g2);
        else if (g1 == SG_ZERO) res = 1'b0;
        else if (g1 == SG_POS) res = (p1 > p2);
        else res = (p1 < p2);
        return res;
    endfunction

    // Keep the later entry and the earlier exit of two spans
    function automatic t_span merge(input t_span a, input t_span b);
        t_span m;
        m = a;
        priority if (!a.have) m = b;
        else if (b.have) begin
            if (frac_gt(b.en, b.ed, a.en, a.ed)) begin
                m.en = b.en;
                m.ed = b.ed;
            end
            if (frac_gt(a.xn, a.xd, b.xn, b.xd)) begin
                m.xn = b.xn;
                m.xd = b.xd;
            end
        end
        return m;
    endfunction

    // ---------------- stage 1: per-axis slab crossings ----------------
    logic signed [NW-1:0] w_nn  [3];
    logic signed [NW-1:0] w_fn  [3];
    logic        [CW-1:0] w_den [3];
    logic                 w_dz  [3];
    logic                 w_in  [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [NW-1:0] o_e;
        logic signed [NW-1:0] v_e;
        logic signed [NW-1:0] c_e;
        logic signed [NW-1:0] h_e;
        logic signed [NW-1:0] slab_lo;
        logic signed [NW-1:0] slab_hi;
        logic signed [NW-1:0] dir;

        assign o_e     = NW'(i_origin[a]);
        assign v_e     = NW'(i_vector[a]);
        assign c_e     = NW'(i_center[a]);
        assign h_e     = NW'(i_half[a]);
        assign dir     = i_action ? v_e - o_e : v_e;
        assign slab_lo = c_e - h_e;
        assign slab_hi = c_e + h_e;

        assign w_dz[a]  = (dir == '0);
        assign w_den[a] = dir[NW-1] ? CW'(-dir) : CW'(dir);
        assign w_nn[a]  = dir[NW-1] ? o_e - slab_hi : slab_lo - o_e;
        assign w_fn[a]  = dir[NW-1] ? o_e - slab_lo : slab_hi - o_e;
        assign w_in[a]  = (o_e >= slab_lo) && (o_e <= slab_hi);
    end

    logic                 r1_valid;
    logic                 r1_seg;
    logic signed [NW-1:0] r1_nn  [3];
    logic signed [NW-1:0] r1_fn  [3];
    logic        [CW-1:0] r1_den [3];
    logic                 r1_dz  [3];
    logic                 r1_in  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_seg <= i_action;
        r1_nn  <= w_nn;
        r1_fn  <= w_fn;
        r1_den <= w_den;
        r1_dz  <= w_dz;
        r1_in  <= w_in;
    end

    // ---------------- stage 2: merge x and y, square directions ----------------
    t_span          w_ax [3];
    t_span          n2_span;
    logic           n2_miss;
    logic           r2_valid;
    logic           r2_seg;
    logic           r2_miss;
    t_span          r2_span;
    t_span          r2_z;
    logic [QW-1:0]  r2_sq [3];

    always_comb begin
        n2_miss = 1'b0;
        for (int a = 0; a < 3; a++) begin
            w_ax[a].have = !r1_dz[a];
            w_ax[a].en   = r1_nn[a];
            w_ax[a].ed   = r1_den[a];
            w_ax[a].xn   = r1_fn[a];
            w_ax[a].xd   = r1_den[a];
            n2_miss      = n2_miss | (r1_dz[a] & ~r1_in[a]);
        end
        n2_span = merge(w_ax[0], w_ax[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_seg  <= r1_seg;
        r2_miss <= n2_miss;
        r2_span <= n2_span;
        r2_z    <= w_ax[2];
        for (int a = 0; a < 3; a++) begin
            r2_sq[a] <= QW'(r1_den[a]) * QW'(r1_den[a]);
        end
    end

    // ---------------- stage 3: merge z, sum squares ----------------
    logic          r3_valid;
    logic          r3_seg;
    logic          r3_miss;
    t_span         r3_span;
    logic [SW-1:0] r3_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_seg  <= r2_seg;
        r3_miss <= r2_miss;
        r3_span <= merge(r2_span, r2_z);
        r3_s    <= SW'(r2_sq[0]) + SW'(r2_sq[1]) + SW'(r2_sq[2]);
    end

    // ---------------- stage 4: hit decision, coarse normalize ----------------
    logic                   n4_hit;
    logic [MW-1:0]          n4_men;
    logic [SQ_WIDTH-1:0]    n4_x;
    logic [SHIFT_WIDTH-1:0] n4_k;
    logic                   r4_valid;
    logic                   r4_hit;
    logic                   r4_neg;
    logic [MW-1:0]          r4_men;
    logic [CW-1:0]          r4_ed;
    logic [SQ_WIDTH-1:0]    r4_x;
    logic [SHIFT_WIDTH-1:0] r4_k;

    always_comb begin
        n4_men = mag_of(r3_span.en);
        n4_hit = r3_span.have && !r3_miss
              && !r3_span.xn[NW-1] && (r3_span.xn != '0)
              && frac_gt(r3_span.xn, r3_span.xd, r3_span.en, r3_span.ed)
              && !(r3_seg && (n4_men > MW'(r3_span.ed)));
        n4_x = SQ_WIDTH'(r3_s);
        n4_k = '0;
        if (n4_x[SQ_WIDTH-1 -: 64] == '0) begin
            n4_x = n4_x << 64;
            n4_k = n4_k + SHIFT_WIDTH'(32);
        end
        if (n4_x[SQ_WIDTH-1 -: 32] == '0) begin
            n4_x = n4_x << 32;
            n4_k = n4_k + SHIFT_WIDTH'(16);
        end
        if (n4_x[SQ_WIDTH-1 -: 16] == '0) begin
            n4_x = n4_x << 16;
            n4_k = n4_k + SHIFT_WIDTH'(8);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_hit <= n4_hit;
        r4_neg <= r3_span.en[NW-1];
        r4_men <= n4_men;
        r4_ed  <= r3_span.ed;
        r4_x   <= n4_x;
        r4_k   <= n4_k;
    end

    // ---------------- stage 5: fine normalize to an even shift ----------------
    logic [SQ_WIDTH-1:0]    n5_x;
    logic [SHIFT_WIDTH-1:0] n5_k;
    t_ctl                   r5_ctl;
    logic [SQ_WIDTH-1:0]    r5_x;
    logic [SHIFT_WIDTH-1:0] r5_k;
    logic [MW-1:0]          r5_men;
    logic [CW-1:0]          r5_ed;

    always_comb begin
        n5_x = r4_x;
        n5_k = r4_k;
        if (n5_x[SQ_WIDTH-1 -: 8] == '0) begin
            n5_x = n5_x << 8;
            n5_k = n5_k + SHIFT_WIDTH'(4);
        end
        if (n5_x[SQ_WIDTH-1 -: 4] == '0) begin
            n5_x = n5_x << 4;
            n5_k = n5_k + SHIFT_WIDTH'(2);
        end
        if (n5_x[SQ_WIDTH-1 -: 2] == '0) begin
            n5_x = n5_x << 2;
            n5_k = n5_k + SHIFT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctl <= '0;
        end else begin
            r5_ctl.valid <= r4_valid;
            r5_ctl.hit   <= r4_hit;
            r5_ctl.neg   <= r4_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_x   <= n5_x;
        r5_k   <= n5_k;
        r5_men <= r4_men;
        r5_ed  <= r4_ed;
    end

    assign o_ctl = r5_ctl;
    assign o_x   = r5_x;
    assign o_k   = r5_k;
    assign o_men = r5_men;
    assign o_ed  = r5_ed;

    // A hit always comes from a nonzero direction and a real crossing
    a_hit_has_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_valid && r4_hit |-> r4_ed != '0)
        else $error("hit with zero entry denominator");

    a_hit_has_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_valid && r4_hit |=> r5_x[SQ_WIDTH-1 -: 2] != '0)
        else $error("hit with unnormalized length");

endmodule

// ===== hdl/rbs_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with side band.
module rbs_isqrt #(
    parameter int SIDE_W = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rbs_pkg::t_ctl                       i_ctl,
    input  logic [rbs_pkg::SQ_WIDTH-1:0]        i_x,
    input  logic [SIDE_W-1:0]                   i_side,
    output rbs_pkg::t_ctl                       o_ctl,
    output logic [rbs_pkg::ROOT_WIDTH-1:0]      o_root,
    output logic [SIDE_W-1:0]                   o_side
);
    import rbs_pkg::*;

    logic [SQ_WIDTH-1:0]   r_rem  [ROOT_WIDTH];
    logic [ROOT_WIDTH-1:0] r_root [ROOT_WIDTH];
    t_ctl                  r_ctl  [ROOT_WIDTH];
    logic [SIDE_W-1:0]     r_side [ROOT_WIDTH];

    for (genvar j = 0; j < ROOT_WIDTH; j++) begin : g_step
        localparam int B = ROOT_WIDTH - 1 - j;
        logic [SQ_WIDTH-1:0]   p_rem;
        logic [ROOT_WIDTH-1:0] p_root;
        t_ctl                  p_ctl;
        logic [SIDE_W-1:0]     p_side;
        logic [SQ_WIDTH-1:0]   w_trial;

        if (j == 0) begin : g_first
            assign p_rem  = i_x;
            assign p_root = '0;
            assign p_ctl  = i_ctl;
            assign p_side = i_side;
        end else begin : g_next
            assign p_rem  = r_rem[j-1];
            assign p_root = r_root[j-1];
            assign p_ctl  = r_ctl[j-1];
            assign p_side = r_side[j-1];
        end

        // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
        assign w_trial = (SQ_WIDTH'(p_root) << (B + 1)) | (SQ_WIDTH'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[j] <= '0;
            end else begin
                r_ctl[j] <= p_ctl;
            end
        end

        // Take the bit when the remainder covers the trial
        always_ff @(posedge i_clk) begin
            if (p_rem >= w_trial) begin
                r_rem[j]  <= p_rem - w_trial;
                r_root[j] <= p_root | (ROOT_WIDTH'(1) << B);
            end else begin
                r_rem[j]  <= p_rem;
                r_root[j] <= p_root;
            end
            r_side[j] <= p_side;
        end
    end

    assign o_ctl  = r_ctl[ROOT_WIDTH-1];
    assign o_root = r_root[ROOT_WIDTH-1];
    assign o_side = r_side[ROOT_WIDTH-1];

endmodule

// ===== hdl/rbs_dist_div.sv =====
// Distance scaling: entry times root, then a one-bit-per-stage divide and saturate.
module rbs_dist_div #(
    parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rbs_pkg::t_ctl                        i_ctl,
    input  logic [rbs_pkg::ROOT_WIDTH-1:0]       i_root,
    input  logic [COORD_WIDTH:0]                 i_men,
    input  logic [COORD_WIDTH-1:0]               i_ed,
    input  logic [rbs_pkg::SHIFT_WIDTH-1:0]      i_k,
    output logic                                 o_valid,
    output logic                                 o_hit,
    output logic signed [COORD_WIDTH-1:0]        o_distance
);
    import rbs_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int MW  = CW + 1;
    localparam int PW  = MW + ROOT_WIDTH;       // entry times root
    localparam int DVW = CW + ROOT_WIDTH;       // scaled denominator
    localparam int RW  = 2 * CW + ROOT_WIDTH;   // divider remainder

    // ---------------- partial products ----------------
    t_ctl                   r1_ctl;
    logic [MW+LO_W-1:0]     r1_pl;
    logic [MW+HI_W-1:0]     r1_ph;
    logic [CW-1:0]          r1_ed;
    logic [SHIFT_WIDTH-1:0] r1_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else begin
            r1_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_pl <= (MW+LO_W)'(i_men) * (MW+LO_W)'(i_root[LO_W-1:0]);
        r1_ph <= (MW+HI_W)'(i_men) * (MW+HI_W)'(i_root[ROOT_WIDTH-1:LO_W]);
        r1_ed <= i_ed;
        r1_k  <= i_k;
    end

    // ---------------- product sum and denominator shift ----------------
    t_ctl           r2_ctl;
    logic [PW-1:0]  r2_p;
    logic [DVW-1:0] r2_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else begin
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_p <= PW'(r1_pl) + (PW'(r1_ph) << LO_W);
        r2_d <= DVW'(r1_ed) << r1_k;
    end

    // ---------------- overflow check ----------------
    t_ctl           r3_ctl;
    logic [RW-1:0]  r3_rem;
    logic [DVW-1:0] r3_d;
    logic           r3_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else begin
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_rem <= RW'(r2_p);
        r3_d   <= r2_d;
        r3_ovf <= RW'(r2_p) >= (RW'(r2_d) << CW);
    end

    // ---------------- restoring divide, one quotient bit per stage ----------------
    t_ctl           r_ctl [CW];
    logic [RW-1:0]  r_rem [CW];
    logic [DVW-1:0] r_dd  [CW];
    logic [CW-1:0]  r_q   [CW];
    logic           r_ovf [CW];

    for (genvar j = 0; j < CW; j++) begin : g_div
        localparam int B = CW - 1 - j;
        t_ctl           p_ctl;
        logic [RW-1:0]  p_rem;
        logic [DVW-1:0] p_dd;
        logic [CW-1:0]  p_q;
        logic           p_ovf;
        logic [RW-1:0]  w_sub;

        if (j == 0) begin : g_first
            assign p_ctl = r3_ctl;
            assign p_rem = r3_rem;
            assign p_dd  = r3_d;
            assign p_q   = '0;
            assign p_ovf = r3_ovf;
        end else begin : g_next
            assign p_ctl = r_ctl[j-1];
            assign p_rem = r_rem[j-1];
            assign p_dd  = r_dd[j-1];
            assign p_q   = r_q[j-1];
            assign p_ovf = r_ovf[j-1];
        end

        assign w_sub = RW'(p_dd) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[j] <= '0;
            end else begin
                r_ctl[j] <= p_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (p_rem >= w_sub) begin
                r_rem[j] <= p_rem - w_sub;
                r_q[j]   <= p_q | (CW'(1) << B);
            end else begin
                r_rem[j] <= p_rem;
                r_q[j]   <= p_q;
            end
            r_dd[j]  <= p_dd;
            r_ovf[j] <= p_ovf;
        end
    end

    // ---------------- saturate, sign and drive the result ----------------
    t_ctl                 w_last;
    logic [CW-1:0]        w_lim;
    logic [CW-1:0]        w_mag;
    logic signed [CW-1:0] n_distance;

    always_comb begin
        w_last = r_ctl[CW-1];
        w_lim  = w_last.neg ? (CW'(1) << (CW - 1)) : ((CW'(1) << (CW - 1)) - CW'(1));
        w_mag  = (r_ovf[CW-1] || (r_q[CW-1] > w_lim)) ? w_lim : r_q[CW-1];
        if (!w_last.hit) n_distance = '0;
        else if (w_last.neg) n_distance = -$signed(w_mag);
        else n_distance = $signed(w_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            o_hit   <= 1'b0;
        end else begin
            o_valid <= w_last.valid;
            o_hit   <= w_last.valid & w_last.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        o_distance <= n_distance;
    end

    // Without overflow the divide must end below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[CW-1].valid && !r_ovf[CW-1] |-> r_rem[CW-1] < RW'(r_dd[CW-1]))
        else $error("divider remainder not below divisor");

endmodule

// ===== hdl/ray_box_slab_intersect_unit.sv =====
// Top level: box registers on the APB port and the slab test pipeline.
// Path: a result strobe follows the accepting edge through 5 slab/merge stages,
// the 63-stage square root, 3 product stages, one divide stage per distance bit
// and an output register.
// Throughput: one beat per cycle; busy stays low and results cannot be held off.
// Reset clears the box registers to zero (a point box) and all valid bits.
module ray_box_slab_intersect_unit #(
    parameter int  COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF,
    localparam int DATA_W      = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_W      = $clog2(rbs_pkg::NUM_REGS * DATA_W / 8)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_action,
    input  logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [COORD_WIDTH-1:0] i_origin_z,
    input  logic signed [COORD_WIDTH-1:0] i_vector_x,
    input  logic signed [COORD_WIDTH-1:0] i_vector_y,
    input  logic signed [COORD_WIDTH-1:0] i_vector_z,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic signed [COORD_WIDTH-1:0] o_distance
);
    import rbs_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int STR_LOG = $clog2(DATA_W / 8);
    localparam int IDX_W   = ADDR_W - STR_LOG;
    localparam int SIDE_W  = (CW + 1) + CW + SHIFT_WIDTH;

    localparam logic [IDX_W-1:0] REG_CENTER_X = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_CENTER_Y = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_CENTER_Z = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_HALF_X   = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_HALF_Y   = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_HALF_Z   = IDX_W'(5);

    // ---------------- configuration registers ----------------
    logic signed [CW-1:0] r_center [3];
    logic        [CW-2:0] r_half   [3];
    logic [IDX_W-1:0]     w_idx;
    logic                 w_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_idx  = paddr[ADDR_W-1:STR_LOG];
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '{default: '0};
            r_half   <= '{default: '0};
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CENTER_X: r_center[0] <= pwdata[CW-1:0];
                REG_CENTER_Y: r_center[1] <= pwdata[CW-1:0];
                REG_CENTER_Z: r_center[2] <= pwdata[CW-1:0];
                REG_HALF_X:   r_half[0]   <= pwdata[CW-2:0];
                REG_HALF_Y:   r_half[1]   <= pwdata[CW-2:0];
                REG_HALF_Z:   r_half[2]   <= pwdata[CW-2:0];
                default: ;
            endcase
        end
    end

    // Read back: centers sign-extended, half extents zero-extended
    always_comb begin
        unique case (w_idx)
            REG_CENTER_X: prdata = DATA_W'(r_center[0]);
            REG_CENTER_Y: prdata = DATA_W'(r_center[1]);
            REG_CENTER_Z: prdata = DATA_W'(r_center[2]);
            REG_HALF_X:   prdata = DATA_W'(r_half[0]);
            REG_HALF_Y:   prdata = DATA_W'(r_half[1]);
            REG_HALF_Z:   prdata = DATA_W'(r_half[2]);
            default:      prdata = '0;
        endcase
    end

    // ---------------- slab front end ----------------
    logic signed [CW-1:0]   w_origin [3];
    logic signed [CW-1:0]   w_vector [3];
    t_ctl                   w_f_ctl;
    logic [SQ_WIDTH-1:0]    w_f_x;
    logic [SHIFT_WIDTH-1:0] w_f_k;
    logic [CW:0]            w_f_men;
    logic [CW-1:0]          w_f_ed;

    assign w_origin[0] = i_origin_x;
    assign w_origin[1] = i_origin_y;
    assign w_origin[2] = i_origin_z;
    assign w_vector[0] = i_vector_x;
    assign w_vector[1] = i_vector_y;
    assign w_vector[2] = i_vector_z;

    rbs_slab_front #(
        .COORD_WIDTH (CW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start & ~busy),
        .i_action (i_action),
        .i_origin (w_origin),
        .i_vector (w_vector),
        .i_center (r_center),
        .i_half   (r_half),
        .o_ctl    (w_f_ctl),
        .o_x      (w_f_x),
        .o_k      (w_f_k),
        .o_men    (w_f_men),
        .o_ed     (w_f_ed)
    );

    // ---------------- length square root ----------------
    t_ctl                   w_s_ctl;
    logic [ROOT_WIDTH-1:0]  w_s_root;
    logic [SIDE_W-1:0]      w_s_side;
    logic [CW:0]            w_s_men;
    logic [CW-1:0]          w_s_ed;
    logic [SHIFT_WIDTH-1:0] w_s_k;

    rbs_isqrt #(
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_f_ctl),
        .i_x     (w_f_x),
        .i_side  ({w_f_men, w_f_ed, w_f_k}),
        .o_ctl   (w_s_ctl),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    assign {w_s_men, w_s_ed, w_s_k} = w_s_side;

    // ---------------- distance scale and divide ----------------
    rbs_dist_div #(
        .COORD_WIDTH (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_s_ctl),
        .i_root     (w_s_root),
        .i_men      (w_s_men),
        .i_ed       (w_s_ed),
        .i_k        (w_s_k),
        .o_valid    (o_valid),
        .o_hit      (o_hit),
        .o_distance (o_distance)
    );

    // A missed beat reports zero distance
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_distance == '0)
        else $error("miss with nonzero distance");

endmodule
